// ===== rtl/windowed_multiset_aggregator_core_macros.svh =====
// Assertion macros for the multiset aggregator core.
// Included by the top level; no other dependencies.
`ifndef WINDOWED_MULTISET_AGGREGATOR_CORE_MACROS_SVH
`define WINDOWED_MULTISET_AGGREGATOR_CORE_MACROS_SVH

// Assert an implication on the clock, skipped in reset.
`define WMA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Assert an implication checked in the cycle after the antecedent, skipped in reset.
`define WMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/wma_pkg.sv =====
// Shared types and constants for the multiset aggregator core.
// No dependencies.
package wma_pkg;
    localparam int KEY_BITS   = 8;
    localparam int COUNT_BITS = 16;
    localparam int TABLE_SIZE = 1 << KEY_BITS;
    localparam int SUM_W      = 24;
    localparam int TCNT_W     = 16;
    localparam int DSUM_W     = 15;
    localparam int DCNT_W     = 9;
    localparam int MEAN_W     = 16;
    localparam int DIV_NUM_W  = SUM_W + 8;

    localparam logic REQ_INSERT  = 1'b0;
    localparam logic REQ_RETRACT = 1'b1;

    // Controller to datapath commands
    typedef struct packed {
        logic clr_step;    // clear one table row (sweep)
        logic capture;     // latch the item
        logic rd_issue;    // read the item's table row
        logic update;      // apply the update
        logic scan_init;   // start an extremes rescan
        logic scan_step;   // read one row of the rescan
        logic div_start;   // start both divisions
        logic div_step;    // one quotient bit each
        logic emit;        // present the result
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic need_scan;
        logic scan_last;
        logic div_last;
    } t_stat;
endpackage

// ===== rtl/wma_ctrl.sv =====
// Controller state machine for the multiset aggregator core.
// Depends on wma_pkg.
module wma_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    input  wma_pkg::t_stat i_stat,
    output wma_pkg::t_cmd  o_cmd
);
    import wma_pkg::*;

    typedef enum logic [7:0] {
        S_CLEAR = 8'b0000_0001,
        S_IDLE  = 8'b0000_0010,
        S_READ  = 8'b0000_0100,
        S_UPD   = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_DIVGO = 8'b0010_0000,
        S_DIV   = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state = S_UPD;
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                if (i_stat.need_scan) begin
                    o_cmd.scan_init = 1'b1;
                    n_state = S_SCAN;
                end else begin
                    n_state = S_DIVGO;
                end
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                if (i_stat.scan_last) n_state = S_DIVGO;
            end
            S_DIVGO: begin
                o_cmd.div_start = 1'b1;
                n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                o_cmd.emit = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);
endmodule

// ===== rtl/wma_dp.sv =====
// Datapath of the multiset aggregator: count table, running totals,
// extremes rescan and two bit-serial dividers. Depends on wma_pkg.
module wma_dp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  wma_pkg::t_cmd                  i_cmd,
    output wma_pkg::t_stat                 o_stat,
    input  logic                           i_req_type,
    input  logic [wma_pkg::KEY_BITS-1:0]   i_key_value,
    output logic                           o_valid,
    output logic                           o_is_empty,
    output logic                           o_bad_request,
    output logic [wma_pkg::SUM_W-1:0]      o_total_sum,
    output logic [wma_pkg::TCNT_W-1:0]     o_total_count,
    output logic [wma_pkg::KEY_BITS-1:0]   o_min_key,
    output logic [wma_pkg::KEY_BITS-1:0]   o_max_key,
    output logic [wma_pkg::DSUM_W-1:0]     o_distinct_total,
    output logic [wma_pkg::DCNT_W-1:0]     o_distinct_count,
    output logic [wma_pkg::MEAN_W-1:0]     o_mean_fixed,
    output logic [wma_pkg::MEAN_W-1:0]     o_distinct_mean_fixed
);
    import wma_pkg::*;

    localparam int DSTEP_W = $clog2(DIV_NUM_W + 1);

    logic [COUNT_BITS-1:0] mem [TABLE_SIZE];
    logic [COUNT_BITS-1:0] r_rd;
    logic [KEY_BITS-1:0]   r_addr;
    logic                  r_type;
    logic [KEY_BITS-1:0]   r_key;

    logic [SUM_W-1:0]    r_sum;
    logic [TCNT_W-1:0]   r_cnt;
    logic [DSUM_W-1:0]   r_dsum;
    logic [DCNT_W-1:0]   r_dcnt;
    logic [KEY_BITS-1:0] r_min, r_max;
    logic                r_bad;
    logic                r_seen;
    logic                r_scan_rd;    // scan read data trails its address through a registered read
    logic [KEY_BITS-1:0] r_scan_key;
    logic                r_scan_addr_done;

    // Decide the update from the read row
    logic                ok, fresh_ins, gone;
    logic [SUM_W:0]      sum_inc;
    logic [DSUM_W:0]     dsum_inc;
    always_comb begin
        sum_inc  = {1'b0, r_sum} + (SUM_W+1)'(r_key);
        dsum_inc = {1'b0, r_dsum} + (DSUM_W+1)'(r_key);
        fresh_ins = (r_rd == '0);
        gone      = (r_rd == COUNT_BITS'(1));
        if (r_type == REQ_RETRACT) begin
            ok = (r_rd != '0);
        end else begin
            ok = (r_rd != '1) && (r_cnt != '1) && !sum_inc[SUM_W]
                 && !(fresh_ins && dsum_inc[DSUM_W]);
        end
    end

    assign o_stat.need_scan = ok && (r_type == REQ_RETRACT ? gone : fresh_ins);
    assign o_stat.clr_last  = (r_addr == '1);
    assign o_stat.scan_last = r_scan_rd && (r_scan_key == '1);

    // Table port: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) mem[r_addr] <= '0;
        if (i_cmd.update && ok)
            mem[r_key] <= (r_type == REQ_RETRACT) ? r_rd - 1'b1 : r_rd + 1'b1;
        if (i_cmd.rd_issue) r_rd <= mem[r_key];
        if (i_cmd.scan_step) r_rd <= mem[r_addr];
    end

    // Sweep address and item capture
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_scan_rd <= 1'b0;
            r_scan_addr_done <= 1'b0;
        end else begin
            if (i_cmd.clr_step) r_addr <= r_addr + 1'b1;
            if (i_cmd.scan_init) begin
                r_addr <= '0;
                r_scan_rd <= 1'b0;
                r_scan_addr_done <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                if (!r_scan_addr_done) begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == '1) r_scan_addr_done <= 1'b1;
                end
                r_scan_rd  <= 1'b1;
                r_scan_key <= r_addr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_type <= i_req_type;
            r_key  <= i_key_value;
        end
    end

    // Running totals and extremes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0; r_cnt <= '0; r_dsum <= '0; r_dcnt <= '0;
            r_min <= '0; r_max <= '0; r_bad <= 1'b0; r_seen <= 1'b0;
        end else begin
            if (i_cmd.update) begin
                r_bad <= !ok;
                if (ok) begin
                    if (r_type == REQ_RETRACT) begin
                        r_sum <= r_sum - SUM_W'(r_key);
                        r_cnt <= r_cnt - 1'b1;
                        if (gone) begin
                            r_dsum <= r_dsum - DSUM_W'(r_key);
                            r_dcnt <= r_dcnt - 1'b1;
                        end
                    end else begin
                        r_sum <= sum_inc[SUM_W-1:0];
                        r_cnt <= r_cnt + 1'b1;
                        if (fresh_ins) begin
                            r_dsum <= dsum_inc[DSUM_W-1:0];
                            r_dcnt <= r_dcnt + 1'b1;
                        end
                    end
                end
            end
            if (i_cmd.scan_init) begin
                r_min <= '0; r_max <= '0; r_seen <= 1'b0;
            end
            if (i_cmd.scan_step && r_scan_rd && r_rd != '0) begin
                if (!r_seen) r_min <= r_scan_key;
                r_seen <= 1'b1;
                r_max  <= r_scan_key;
            end
        end
    end

    // Two restoring dividers, one quotient bit per cycle
    logic [DIV_NUM_W-1:0] r_n0, r_n1, r_q0, r_q1;
    logic [TCNT_W:0]      r_p0;
    logic [DCNT_W:0]      r_p1;
    logic [DSTEP_W-1:0]   r_dstep;
    logic [TCNT_W:0]      t0;
    logic [DCNT_W:0]      t1;
    always_comb begin
        t0 = {r_p0[TCNT_W-1:0], r_n0[DIV_NUM_W-1]};
        t1 = {r_p1[DCNT_W-1:0], r_n1[DIV_NUM_W-1]};
    end
    assign o_stat.div_last = (r_dstep == DSTEP_W'(DIV_NUM_W - 1));

    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start) begin
            r_n0 <= {r_sum, 8'b0};
            r_n1 <= DIV_NUM_W'({r_dsum, 8'b0});
            r_q0 <= '0; r_q1 <= '0; r_p0 <= '0; r_p1 <= '0;
            r_dstep <= '0;
        end
        if (i_cmd.div_step) begin
            r_n0 <= r_n0 << 1;
            r_n1 <= r_n1 << 1;
            r_dstep <= r_dstep + 1'b1;
            if (t0 >= {1'b0, r_cnt}) begin
                r_p0 <= t0 - {1'b0, r_cnt};
                r_q0 <= {r_q0[DIV_NUM_W-2:0], 1'b1};
            end else begin
                r_p0 <= t0;
                r_q0 <= {r_q0[DIV_NUM_W-2:0], 1'b0};
            end
            if (t1 >= {1'b0, r_dcnt}) begin
                r_p1 <= t1 - {1'b0, r_dcnt};
                r_q1 <= {r_q1[DIV_NUM_W-2:0], 1'b1};
            end else begin
                r_p1 <= t1;
                r_q1 <= {r_q1[DIV_NUM_W-2:0], 1'b0};
            end
        end
    end

    // Result beat
    logic empty;
    assign empty = (r_cnt == '0);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_cmd.emit;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_is_empty       <= empty;
            o_bad_request    <= r_bad;
            o_total_sum      <= empty ? '0 : r_sum;
            o_total_count    <= r_cnt;
            o_min_key        <= empty ? '0 : r_min;
            o_max_key        <= empty ? '0 : r_max;
            o_distinct_total <= empty ? '0 : r_dsum;
            o_distinct_count <= empty ? '0 : r_dcnt;
            o_mean_fixed <= empty ? '0 :
                (r_q0[DIV_NUM_W-1:MEAN_W] != '0) ? '1 : r_q0[MEAN_W-1:0];
            o_distinct_mean_fixed <= empty ? '0 :
                (r_q1[DIV_NUM_W-1:MEAN_W] != '0) ? '1 : r_q1[MEAN_W-1:0];
        end
    end
endmodule

// ===== rtl/windowed_multiset_aggregator_core.sv =====
// Multiset aggregator core: counts table with running aggregates and means.
// Each item goes through read, update, an optional extremes rescan (a walk
// of the whole table), the division pair and emit; o_valid is registered.
// One item at a time: busy stays high until the result beat, so the next
// beat is not accepted before the result of the last; the receiver cannot stall.
// After reset a clearing pass over the table holds busy high.
`include "windowed_multiset_aggregator_core_macros.svh"
module windowed_multiset_aggregator_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_req_type,
    input  logic [wma_pkg::KEY_BITS-1:0]   i_key_value,
    output logic                           o_valid,
    output logic                           o_is_empty,
    output logic                           o_bad_request,
    output logic [wma_pkg::SUM_W-1:0]      o_total_sum,
    output logic [wma_pkg::TCNT_W-1:0]     o_total_count,
    output logic [wma_pkg::KEY_BITS-1:0]   o_min_key,
    output logic [wma_pkg::KEY_BITS-1:0]   o_max_key,
    output logic [wma_pkg::DSUM_W-1:0]     o_distinct_total,
    output logic [wma_pkg::DCNT_W-1:0]     o_distinct_count,
    output logic [wma_pkg::MEAN_W-1:0]     o_mean_fixed,
    output logic [wma_pkg::MEAN_W-1:0]     o_distinct_mean_fixed
);
    import wma_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    wma_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_start(start), .o_busy(busy),
        .i_stat(stat), .o_cmd(cmd)
    );

    wma_dp u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .o_stat(stat),
        .i_req_type, .i_key_value, .o_valid, .o_is_empty, .o_bad_request,
        .o_total_sum, .o_total_count, .o_min_key, .o_max_key,
        .o_distinct_total, .o_distinct_count, .o_mean_fixed,
        .o_distinct_mean_fixed
    );

    // Checks
    `WMA_ASSERT_NEXT(a_emit_valid, i_clk, i_rst_n, cmd.emit, o_valid)
    `WMA_ASSERT_IMP(a_empty_zero, i_clk, i_rst_n, o_valid && o_is_empty,
        o_total_sum == '0 && o_mean_fixed == '0)
    `WMA_ASSERT_IMP(a_valid_busy, i_clk, i_rst_n, o_valid, !$past(start && !busy))
endmodule

// ===== test/tb_windowed_multiset_aggregator_core.sv =====
// Self-checking testbench for the multiset aggregator core.
// Depends on wma_pkg and windowed_multiset_aggregator_core.
// Predicts every result beat in a scoreboard class and compares field by field.
class wma_scoreboard;
    int unsigned occ [wma_pkg::TABLE_SIZE];
    longint unsigned sum_all, cnt_all, sum_dist, cnt_dist;
    int unsigned lo_key, hi_key;
    typedef struct {
        bit               empty;
        bit               bad;
        longint unsigned  tsum, tcnt, mn, mx, dsum, dcnt, mean, dmean;
    } agg_t;
    agg_t pending[$];
    int unsigned errors;

    function new();
        foreach (occ[k]) occ[k] = 0;
        sum_all = 0; cnt_all = 0; sum_dist = 0; cnt_dist = 0;
        lo_key = 0; hi_key = 0; errors = 0;
    endfunction

    // Recompute the smallest and largest key present
    function void rescan();
        bit seen;
        seen = 0; lo_key = 0; hi_key = 0;
        for (int k = 0; k < wma_pkg::TABLE_SIZE; k++) begin
            if (occ[k] != 0) begin
                if (!seen) lo_key = k;
                seen = 1;
                hi_key = k;
            end
        end
    endfunction

    function longint unsigned fx_mean(longint unsigned num, longint unsigned den);
        longint unsigned q;
        if (den == 0) return 0;
        q = (num << 8) / den;
        return (q > 64'hFFFF) ? 64'hFFFF : q;
    endfunction

    // Apply one accepted beat and queue the expected result
    function void note_input(logic req, logic [7:0] key);
        agg_t a;
        bit fresh;
        a = '{default: 0};
        if (req == wma_pkg::REQ_RETRACT) begin
            if (occ[key] == 0) a.bad = 1;
            else begin
                occ[key]--; cnt_all--; sum_all -= key;
                if (occ[key] == 0) begin
                    sum_dist -= key; cnt_dist--; rescan();
                end
            end
        end else begin
            fresh = (occ[key] == 0);
            if (occ[key] >= 16'hFFFF || cnt_all >= 16'hFFFF ||
                sum_all + key > 24'hFFFFFF || (fresh && sum_dist + key > 15'h7FFF))
                a.bad = 1;
            else begin
                occ[key]++; cnt_all++; sum_all += key;
                if (fresh) begin
                    sum_dist += key; cnt_dist++; rescan();
                end
            end
        end
        if (cnt_all == 0) a.empty = 1;
        else begin
            a.tsum = sum_all; a.tcnt = cnt_all; a.mn = lo_key; a.mx = hi_key;
            a.dsum = sum_dist; a.dcnt = cnt_dist;
            a.mean = fx_mean(sum_all, cnt_all);
            a.dmean = fx_mean(sum_dist, cnt_dist);
        end
        pending.push_back(a);
    endfunction

    task report(string what, longint unsigned got, longint unsigned want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    // Compare one result beat with the oldest expectation
    task check_result(bit empty, bit bad, longint unsigned tsum, tcnt, mn, mx,
                      dsum, dcnt, mean, dmean);
        agg_t e;
        if (pending.size() == 0) begin
            report("unexpected beat", 1, 0);
            return;
        end
        e = pending.pop_front();
        if (empty != e.empty) report("is_empty", empty, e.empty);
        if (bad != e.bad) report("bad_request", bad, e.bad);
        if (tsum != e.tsum) report("total_sum", tsum, e.tsum);
        if (tcnt != e.tcnt) report("total_count", tcnt, e.tcnt);
        if (mn != e.mn) report("min_key", mn, e.mn);
        if (mx != e.mx) report("max_key", mx, e.mx);
        if (dsum != e.dsum) report("distinct_total", dsum, e.dsum);
        if (dcnt != e.dcnt) report("distinct_count", dcnt, e.dcnt);
        if (mean != e.mean) report("mean_fixed", mean, e.mean);
        if (dmean != e.dmean) report("distinct_mean_fixed", dmean, e.dmean);
    endtask
endclass

module tb_windowed_multiset_aggregator_core;
    timeunit 1ns;
    timeprecision 1ps;

    logic i_clk, i_rst_n, start, busy, i_req_type;
    logic [wma_pkg::KEY_BITS-1:0] i_key_value;
    logic o_valid, o_is_empty, o_bad_request;
    logic [wma_pkg::SUM_W-1:0] o_total_sum;
    logic [wma_pkg::TCNT_W-1:0] o_total_count;
    logic [wma_pkg::KEY_BITS-1:0] o_min_key, o_max_key;
    logic [wma_pkg::DSUM_W-1:0] o_distinct_total;
    logic [wma_pkg::DCNT_W-1:0] o_distinct_count;
    logic [wma_pkg::MEAN_W-1:0] o_mean_fixed, o_distinct_mean_fixed;

    wma_scoreboard multiset_sb;
    int burst_left;

    windowed_multiset_aggregator_core dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // Check every result beat at the edge that ends it
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid)
            multiset_sb.check_result(o_is_empty, o_bad_request, o_total_sum, o_total_count,
                o_min_key, o_max_key, o_distinct_total, o_distinct_count, o_mean_fixed,
                o_distinct_mean_fixed);
    end

    // Present one beat and hold it until accepted; start drops only for a gap
    task send_beat(logic req, logic [7:0] key);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap != 0) begin
                start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        start <= 1'b1;
        i_req_type <= req;
        i_key_value <= key;
        do @(posedge i_clk); while (busy);
        multiset_sb.note_input(req, key);
    endtask

    initial begin
        int live[$];
        int k;
        multiset_sb = new();
        burst_left = 0;
        i_rst_n = 0; start = 0; i_req_type = 0; i_key_value = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty retract, extremes, duplicates, min/max retraction
        send_beat(wma_pkg::REQ_RETRACT, 8'd0);
        send_beat(wma_pkg::REQ_INSERT, 8'd0);
        send_beat(wma_pkg::REQ_RETRACT, 8'd0);
        send_beat(wma_pkg::REQ_INSERT, 8'd255);
        send_beat(wma_pkg::REQ_INSERT, 8'd255);
        send_beat(wma_pkg::REQ_INSERT, 8'd1);
        send_beat(wma_pkg::REQ_INSERT, 8'd128);
        send_beat(wma_pkg::REQ_INSERT, 8'd0);
        send_beat(wma_pkg::REQ_RETRACT, 8'd0);
        send_beat(wma_pkg::REQ_RETRACT, 8'd1);
        send_beat(wma_pkg::REQ_RETRACT, 8'd255);
        send_beat(wma_pkg::REQ_RETRACT, 8'd255);
        send_beat(wma_pkg::REQ_RETRACT, 8'd77);
        send_beat(wma_pkg::REQ_RETRACT, 8'd128);
        // Distinct sum and count at their largest: insert every key once, largest first
        for (int j = 255; j >= 0; j--) send_beat(wma_pkg::REQ_INSERT, j[7:0]);
        for (int j = 0; j < 256; j++) send_beat(wma_pkg::REQ_RETRACT, j[7:0]);

        // Random: mostly retract keys that are present, keep the set small
        for (int n = 0; n < 1500; n++) begin
            if (live.size() > 0 && $urandom_range(0, 99) < 45) begin
                k = $urandom_range(0, live.size() - 1);
                send_beat(wma_pkg::REQ_RETRACT, live[k][7:0]);
                live.delete(k);
            end else if ($urandom_range(0, 9) == 0) begin
                k = $urandom_range(0, 255);
                send_beat(wma_pkg::REQ_RETRACT, k[7:0]);
            end else begin
                k = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                : $urandom_range(0, 7) * 36;
                send_beat(wma_pkg::REQ_INSERT, k[7:0]);
                if (multiset_sb.occ[k] != 0) live.push_back(k);
            end
        end
        start <= 1'b0;

        // Drain, then allow the longest latency
        while (multiset_sb.pending.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
        if (multiset_sb.errors == 0)
            $display("tb_windowed_multiset_aggregator_core: done, clean");
        else
            $display("tb_windowed_multiset_aggregator_core: done, errors");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb_windowed_multiset_aggregator_core: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/wma_pkg.sv
rtl/wma_ctrl.sv
rtl/wma_dp.sv
rtl/windowed_multiset_aggregator_core.sv
test/tb_windowed_multiset_aggregator_core.sv
